/* design/dmrle_pkg.sv */
package dmrle_pkg;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 6;
    localparam int LIMIT_W = 21;
    localparam int STAT_W  = 2;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // marker classification
    localparam logic [BYTE_W-1:0] MARK_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] PCX_MARK  = 8'hC0;
    localparam logic [BYTE_W-1:0] RLE8_MARK = 8'h40;

    // decode modes
    localparam logic MODE_PCX  = 1'b0;
    localparam logic MODE_RLE8 = 1'b1;

    // register index (byte address bit 2)
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_DANGLING = 2'd2,
        ST_SHORT    = 2'd3
    } t_status;

    // one queued command: a byte with the number of copies to emit
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic              last;
        logic              dangling;
    } t_cmd;

endpackage

/* design/dmrle_if.sv */
interface dmrle_in_if;
    logic                        valid;
    logic                        ready;
    logic [dmrle_pkg::BYTE_W-1:0] code_byte;
    logic                        stream_last;

    modport source (output valid, output code_byte, output stream_last, input ready);
    modport sink   (input valid, input code_byte, input stream_last, output ready);
endinterface

interface dmrle_out_if;
    logic                         valid;
    logic                         ready;
    logic [dmrle_pkg::BYTE_W-1:0] pixel_byte;
    logic                         has_byte;
    logic                         run_end;
    logic                         stream_end;
    logic [dmrle_pkg::STAT_W-1:0] end_status;

    modport source (output valid, output pixel_byte, output has_byte, output run_end,
                    output stream_end, output end_status, input ready);
    modport sink   (input valid, input pixel_byte, input has_byte, input run_end,
                    input stream_end, input end_status, output ready);
endinterface

/* design/dmrle_fifo.sv */
module dmrle_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dmrle_pkg::t_cmd i_cmd,
    input  logic            i_pop,
    output dmrle_pkg::t_cmd o_cmd,
    output logic            o_empty,
    output logic            o_full
);
    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    dmrle_pkg::t_cmd  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end
endmodule

/* design/dmrle_front.sv */
module dmrle_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_mode,
    dmrle_in_if.sink        i_in,
    input  logic            i_q_full,
    output logic            o_push,
    output dmrle_pkg::t_cmd o_cmd
);
    logic                        r_pend;
    logic [dmrle_pkg::CNT_W-1:0] r_pcnt;
    logic                        n_pend;
    logic [dmrle_pkg::CNT_W-1:0] n_pcnt;
    logic                        accept;
    logic                        is_marker;
    logic [dmrle_pkg::BYTE_W-1:0] top_bits;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign top_bits   = i_in.code_byte & dmrle_pkg::MARK_MASK;
    assign is_marker  = (i_mode == dmrle_pkg::MODE_RLE8) ? (top_bits == dmrle_pkg::RLE8_MARK)
                                                         : (top_bits == dmrle_pkg::PCX_MARK);

    // classify: run data byte, new marker, or literal
    always_comb begin
        o_cmd.data     = i_in.code_byte;
        o_cmd.last     = i_in.stream_last;
        o_cmd.dangling = 1'b0;
        o_cmd.count    = '0;
        n_pend         = r_pend;
        n_pcnt         = r_pcnt;
        if (r_pend) begin
            o_cmd.count = r_pcnt;
            n_pend      = 1'b0;
            n_pcnt      = '0;
        end else if (is_marker) begin
            n_pend         = 1'b1;
            n_pcnt         = i_in.code_byte[dmrle_pkg::CNT_W-1:0];
            o_cmd.dangling = i_in.stream_last;
        end else begin
            o_cmd.count = dmrle_pkg::CNT_W'(1);
        end
        if (i_in.stream_last) begin
            n_pend = 1'b0;
            n_pcnt = '0;
        end
    end

    // only items that emit something or close the stream go to the queue
    assign o_push = accept && ((o_cmd.count != '0) || i_in.stream_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_pcnt <= '0;
        end else if (accept) begin
            r_pend <= n_pend;
            r_pcnt <= n_pcnt;
        end
    end
endmodule

/* design/dmrle_back.sv */
module dmrle_back #(
    parameter int BO_W = 21
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [BO_W-1:0] i_lim,
    input  logic            i_empty,
    input  dmrle_pkg::t_cmd i_cmd,
    output logic            o_pop,
    dmrle_out_if.source     o_out
);
    localparam int CMP_W = (BO_W > dmrle_pkg::CNT_W) ? BO_W : dmrle_pkg::CNT_W;

    // stream counters
    logic [BO_W-1:0] r_bytes_out, n_bytes_out;
    logic            r_ovf, n_ovf;
    // run in progress
    logic                         r_busy, n_busy;
    logic [dmrle_pkg::CNT_W-1:0]  r_left, n_left;
    logic [dmrle_pkg::BYTE_W-1:0] r_byte, n_byte;
    logic                         r_last, n_last;
    dmrle_pkg::t_status           r_stat, n_stat;
    // output register
    logic                         r_ovalid, n_ovalid;
    logic [dmrle_pkg::BYTE_W-1:0] r_pix, n_pix;
    logic                         r_has, n_has;
    logic                         r_run_end, n_run_end;
    logic                         r_stream_end, n_stream_end;
    dmrle_pkg::t_status           r_status, n_status;

    logic                        out_free;
    logic                        load;
    logic [BO_W-1:0]             rem;
    logic [CMP_W-1:0]            rem_x;
    logic [CMP_W-1:0]            cnt_x;
    logic                        over;
    logic [dmrle_pkg::CNT_W-1:0] emit;
    logic                        single;
    dmrle_pkg::t_status          stat;

    assign out_free = !r_ovalid || o_out.ready;
    assign load     = !r_busy && !i_empty && out_free;
    assign o_pop    = load;

    // clip the command against what is left of the limit (none once a lowered
    // limit is already passed)
    assign rem    = (r_bytes_out >= i_lim) ? '0 : i_lim - r_bytes_out;
    assign rem_x  = CMP_W'(rem);
    assign cnt_x  = CMP_W'(i_cmd.count);
    assign over   = cnt_x > rem_x;
    assign emit   = over ? rem_x[dmrle_pkg::CNT_W-1:0] : i_cmd.count;
    assign single = (emit <= dmrle_pkg::CNT_W'(1));

    // end status: dangling over overflow over short
    always_comb begin
        if (i_cmd.dangling) begin
            stat = dmrle_pkg::ST_DANGLING;
        end else if (r_ovf || over) begin
            stat = dmrle_pkg::ST_OVERFLOW;
        end else if (cnt_x != rem_x) begin
            stat = dmrle_pkg::ST_SHORT;
        end else begin
            stat = dmrle_pkg::ST_OK;
        end
    end

    always_comb begin
        n_bytes_out  = r_bytes_out;
        n_ovf        = r_ovf;
        n_busy       = r_busy;
        n_left       = r_left;
        n_byte       = r_byte;
        n_last       = r_last;
        n_stat       = r_stat;
        n_ovalid     = r_ovalid && !o_out.ready;
        n_pix        = r_pix;
        n_has        = r_has;
        n_run_end    = r_run_end;
        n_stream_end = r_stream_end;
        n_status     = r_status;
        if (r_busy && out_free) begin
            // repeat the run byte
            n_ovalid     = 1'b1;
            n_pix        = r_byte;
            n_has        = 1'b1;
            n_run_end    = (r_left == dmrle_pkg::CNT_W'(1));
            n_stream_end = n_run_end && r_last;
            n_status     = n_stream_end ? r_stat : dmrle_pkg::ST_OK;
            n_left       = r_left - 1'b1;
            if (n_run_end) begin
                n_busy = 1'b0;
            end
        end else if (load) begin
            // first result of the command goes out right away
            n_bytes_out = i_cmd.last ? '0 : r_bytes_out + BO_W'(emit);
            n_ovf       = i_cmd.last ? 1'b0 : (r_ovf || over);
            if ((emit != '0) || i_cmd.last) begin
                n_ovalid     = 1'b1;
                n_pix        = (emit != '0) ? i_cmd.data : '0;
                n_has        = (emit != '0);
                n_run_end    = single;
                n_stream_end = single && i_cmd.last;
                n_status     = n_stream_end ? stat : dmrle_pkg::ST_OK;
            end
            if (!single) begin
                n_busy = 1'b1;
                n_left = emit - 1'b1;
                n_byte = i_cmd.data;
                n_last = i_cmd.last;
                n_stat = stat;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_out <= '0;
            r_ovf       <= 1'b0;
            r_busy      <= 1'b0;
            r_left      <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_bytes_out <= n_bytes_out;
            r_ovf       <= n_ovf;
            r_busy      <= n_busy;
            r_left      <= n_left;
            r_ovalid    <= n_ovalid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_byte       <= n_byte;
        r_last       <= n_last;
        r_stat       <= n_stat;
        r_pix        <= n_pix;
        r_has        <= n_has;
        r_run_end    <= n_run_end;
        r_stream_end <= n_stream_end;
        r_status     <= n_status;
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.pixel_byte = r_pix;
    assign o_out.has_byte   = r_has;
    assign o_out.run_end    = r_run_end;
    assign o_out.stream_end = r_stream_end;
    assign o_out.end_status = r_status;
endmodule

/* design/dual_mode_rle_byte_decoder.sv */
// A byte that emits goes through the command queue and then into the output register.
// Throughput: one item per cycle for literals and markers while the output is not stalled; a run of
// bytes holds the back end, which repeats them through the single output register, while a 4-entry command
// queue lets the front keep taking items. Zero-length runs and marker bytes emit nothing.
// Reset (synchronous, active low) clears the queue, run and stream state, and both
// configuration registers.
module dual_mode_rle_byte_decoder #(
    parameter int MAX_OUT_BYTES = 1048576
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dmrle_in_if.sink                       i_in,
    dmrle_out_if.source                    o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dmrle_pkg::ADDR_W-1:0]   paddr,
    input  logic [dmrle_pkg::DATA_W-1:0]   pwdata,
    output logic [dmrle_pkg::DATA_W-1:0]   prdata,
    output logic                           pready
);
    localparam int LIM_MAX = (MAX_OUT_BYTES < 2097151) ? MAX_OUT_BYTES : 2097151;
    localparam int BO_W    = $clog2(LIM_MAX + 1);
    localparam logic [24:0] LIM_CAP = 25'(LIM_MAX);

    logic                             r_mode;
    logic [dmrle_pkg::LIMIT_W-1:0]    r_out_limit;
    logic [BO_W-1:0]                  r_lim;
    logic                             wr_en;
    logic [dmrle_pkg::LIMIT_W-1:0]    wr_limit;
    logic [BO_W-1:0]                  wr_lim;
    logic                             q_push;
    logic                             q_pop;
    logic                             q_empty;
    logic                             q_full;
    dmrle_pkg::t_cmd                  push_cmd;
    dmrle_pkg::t_cmd                  head_cmd;

    // configuration port
    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;
    assign wr_limit = pwdata[dmrle_pkg::LIMIT_W-1:0];
    assign wr_lim   = (25'(wr_limit) > LIM_CAP) ? LIM_CAP[BO_W-1:0] : wr_limit[BO_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= dmrle_pkg::MODE_PCX;
            r_out_limit <= '0;
            r_lim       <= '0;
        end else if (wr_en) begin
            case (paddr[2])
                dmrle_pkg::REG_MODE: begin
                    r_mode <= pwdata[0];
                end
                dmrle_pkg::REG_LIMIT: begin
                    r_out_limit <= wr_limit;
                    r_lim       <= wr_lim;
                end
                default: begin
                    r_mode <= r_mode;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            dmrle_pkg::REG_MODE:  prdata = dmrle_pkg::DATA_W'(r_mode);
            dmrle_pkg::REG_LIMIT: prdata = dmrle_pkg::DATA_W'(r_out_limit);
            default:              prdata = '0;
        endcase
    end

    dmrle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mode   (r_mode),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (push_cmd)
    );

    dmrle_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    dmrle_back #(
        .BO_W (BO_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lim   (r_lim),
        .i_empty (q_empty),
        .i_cmd   (head_cmd),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );
endmodule

/* design/dmrle_chk.sv */
module dmrle_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         i_ready,
    input logic [dmrle_pkg::BYTE_W-1:0] i_pixel_byte,
    input logic                         i_has_byte,
    input logic                         i_run_end,
    input logic                         i_stream_end,
    input logic [dmrle_pkg::STAT_W-1:0] i_end_status
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_pixel_byte) && $stable(i_end_status))
        else $error("result changed while stalled");

    // an empty result only closes a stream
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_has_byte |-> i_stream_end && i_run_end && (i_pixel_byte == '0))
        else $error("empty result outside stream end");

    // stream end is always the last result of its item
    a_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_stream_end |-> i_run_end)
        else $error("stream end without run end");

    // status only rides on stream end
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_stream_end |-> (i_end_status == dmrle_pkg::ST_OK))
        else $error("end status outside stream end");
endmodule

bind dual_mode_rle_byte_decoder dmrle_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_out.valid),
    .i_ready      (o_out.ready),
    .i_pixel_byte (o_out.pixel_byte),
    .i_has_byte   (o_out.has_byte),
    .i_run_end    (o_out.run_end),
    .i_stream_end (o_out.stream_end),
    .i_end_status (o_out.end_status)
);
